// ===== hw/rtl/ffla_pkg.sv =====
// Shared types and codes for the free-list unit allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffla_pkg;

    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int IDX_SPACE = 256;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_USED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic load;   // request accepted: capture it and read both memories
        logic exec;   // memory data ready: decide, update, post the result
    } ffla_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffla_ctrl.sv =====
// Controller: sequences the accept and execute steps of each request.
`timescale 1ns / 1ps
`default_nettype none

module ffla_ctrl
    import ffla_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output ffla_cmd_t      cmd,
    output logic           busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ffla_state_t;

    ffla_state_t state_reg;
    ffla_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ffla_dp.sv =====
// Datapath: free queue, in-use flags, pointers, high-water mark and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ffla_dp
    import ffla_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ffla_cmd_t        cmd,
    input  wire logic [1:0]       req_type,
    input  wire logic [IDX_W-1:0] free_index,
    output logic                  done,
    output logic [IDX_W-1:0]      unit_index,
    output logic [1:0]            status
);

    localparam logic [CNT_W-1:0] CAP_HW = CNT_W'(CAPACITY);

    logic [IDX_W-1:0] queue_mem [IDX_SPACE];
    logic             flag_mem  [IDX_SPACE];

    logic [1:0]       req_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] q_rd_reg;
    logic             flag_rd_reg;

    logic [IDX_W-1:0] head_reg,  head_next;
    logic [IDX_W-1:0] tail_reg,  tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] hw_reg,    hw_next;
    logic             done_reg;
    logic [IDX_W-1:0] unit_index_reg, unit_index_next;
    logic [1:0]       status_reg,     status_next;

    logic             q_we;
    logic             f_we;
    logic [IDX_W-1:0] f_waddr;
    logic             f_wdata;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        unit_index_next = '0;
        status_next     = ST_OK;
        q_we            = 1'b0;
        f_we            = 1'b0;
        f_waddr         = idx_reg;
        f_wdata         = 1'b0;
        case (req_reg)
            REQ_ALLOC:
            begin
                if (count_reg != '0)
                begin
                    // reuse the oldest freed index
                    unit_index_next = q_rd_reg;
                    head_next       = head_reg + 1'b1;
                    count_next      = count_reg - 1'b1;
                    f_we            = 1'b1;
                    f_waddr         = q_rd_reg;
                    f_wdata         = 1'b1;
                end
                else if (hw_reg >= CAP_HW)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    unit_index_next = hw_reg[IDX_W-1:0];
                    hw_next         = hw_reg + 1'b1;
                    f_we            = 1'b1;
                    f_waddr         = hw_reg[IDX_W-1:0];
                    f_wdata         = 1'b1;
                end
            end
            REQ_FREE:
            begin
                if ({1'b0, idx_reg} >= hw_reg)
                begin
                    status_next = ST_RANGE;
                end
                else if (!flag_rd_reg || count_reg[CNT_W-1])
                begin
                    status_next = ST_NOT_USED;
                end
                else
                begin
                    f_we       = 1'b1;
                    q_we       = 1'b1;
                    tail_next  = tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                hw_next    = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Memories and payload: read on accept, write on execute.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= req_type;
            idx_reg     <= free_index;
            q_rd_reg    <= queue_mem[head_reg];
            flag_rd_reg <= flag_mem[free_index];
        end
        if (cmd.exec)
        begin
            unit_index_reg <= unit_index_next;
            status_reg     <= status_next;
            if (q_we)
            begin
                queue_mem[tail_reg] <= idx_reg;
            end
            if (f_we)
            begin
                flag_mem[f_waddr] <= f_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            hw_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                hw_reg    <= hw_next;
            end
        end
    end

    assign done       = done_reg;
    assign unit_index = unit_index_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_free_list_unit_allocator_top.sv =====
// Top level of the free-list unit allocator: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Hands out unit indices and takes them back. Drive req_type and free_index
// with start while busy is low; each request has an accept step and an execute step: the accept
// cycle reads the free-queue memory at the head and the in-use flag memory at
// free_index, and the following cycle (busy high) decides and writes both
// memories. The result appears on unit_index and status with done high for
// exactly one cycle right after that, and a new request may be started in the
// same cycle. The receiver cannot stall the block. Freed indices are reused
// oldest first; fresh indices come from a high-water mark up to
// min(MAX_UNITS, 256). No clearing pass is needed after reset.
module fifo_free_list_unit_allocator_top
    import ffla_pkg::*;
#(
    parameter int MAX_UNITS = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       req_type,
    input  wire logic [IDX_W-1:0] free_index,
    output logic                  done,
    output logic [IDX_W-1:0]      unit_index,
    output logic [1:0]            status
);

    localparam int CAPACITY = (MAX_UNITS > IDX_SPACE) ? IDX_SPACE : MAX_UNITS;

    ffla_cmd_t cmd;

    ffla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy)
    );

    ffla_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .free_index (free_index),
        .done       (done),
        .unit_index (unit_index),
        .status     (status)
    );

    // Each accepted request enters execute once, and execute ends with its result posted.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter execute");

    a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("execute did not post exactly one result");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in execute");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (unit_index == '0))
        else $error("failed request returned a nonzero index");

endmodule

`default_nettype wire

// ===== bench/tb_fifo_free_list_unit_allocator_top.sv =====
// Testbench for the free-list unit allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_fifo_free_list_unit_allocator_top;
    import ffla_pkg::*;

    localparam int UNITS      = 256;
    localparam int CAPACITY   = (UNITS > IDX_SPACE) ? IDX_SPACE : UNITS;
    localparam int ITEMS      = 750;
    localparam int QUIET_MAX  = 2000;
    localparam int TAIL       = 8;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] index;
        logic             drain;   // hold until nothing is in flight
    } alloc_request_t;

    typedef struct packed {
        logic [IDX_W-1:0] unit_index;
        logic [1:0]       status;
    } alloc_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       req_type = REQ_ALLOC;
    logic [IDX_W-1:0] free_index = '0;
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] unit_index;
    logic [1:0]       status;

    alloc_request_t request_q[$];
    alloc_result_t  expected_results[$];
    int             in_flight = 0;
    int             accepted_total = 0;
    int             error_count = 0;
    int             quiet_cycles = 0;
    logic           took;
    alloc_result_t  predicted;
    alloc_result_t  want;

    // Predicted allocator state.
    bit               unit_taken[IDX_SPACE];
    logic [IDX_W-1:0] recycle_mem[IDX_SPACE];
    logic [IDX_W-1:0] recycle_head;
    logic [IDX_W-1:0] recycle_tail;
    logic [CNT_W-1:0] recycle_count;
    logic [CNT_W-1:0] fresh_mark;

    // Stimulus planning view: which indices are live, to aim frees at them.
    bit               plan_live[IDX_SPACE];
    int               plan_hw = 0;
    logic [IDX_W-1:0] plan_recycled[$];

    fifo_free_list_unit_allocator_top #(
        .MAX_UNITS (UNITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .free_index (free_index),
        .done       (done),
        .unit_index (unit_index),
        .status     (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic void resolve_request(input logic [1:0] kind,
                                            input logic [IDX_W-1:0] index,
                                            output alloc_result_t res);
        res = '0;
        res.status = ST_OK;
        case (kind)
            REQ_ALLOC:
            begin
                if (recycle_count != 0)
                begin
                    res.unit_index = recycle_mem[recycle_head];
                    recycle_head = recycle_head + 1'b1;
                    recycle_count = recycle_count - 1'b1;
                    unit_taken[res.unit_index] = 1'b1;
                end
                else if (fresh_mark >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    res.unit_index = fresh_mark[IDX_W-1:0];
                    fresh_mark = fresh_mark + 1'b1;
                    unit_taken[res.unit_index] = 1'b1;
                end
            end
            REQ_FREE:
            begin
                if ({1'b0, index} >= fresh_mark)
                    res.status = ST_RANGE;
                else if (!unit_taken[index] || recycle_count[CNT_W-1])
                    res.status = ST_NOT_USED;
                else
                begin
                    unit_taken[index] = 1'b0;
                    recycle_mem[recycle_tail] = index;
                    recycle_tail = recycle_tail + 1'b1;
                    recycle_count = recycle_count + 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                recycle_head = '0;
                recycle_tail = '0;
                recycle_count = '0;
                fresh_mark = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int sender_idle_pct();
        if (accepted_total < ITEMS / 3)
            return 17;
        else if (accepted_total < 2 * ITEMS / 3)
            return 59;
        return 0;
    endfunction

    task automatic add_request(input logic [1:0] kind, input logic [IDX_W-1:0] index,
                               input logic drain);
        alloc_request_t item;
        logic [IDX_W-1:0] reuse;
        item.kind = kind;
        item.index = index;
        item.drain = drain;
        request_q = {request_q, item};
        case (kind)
            REQ_ALLOC:
            begin
                if (plan_recycled.size() != 0)
                begin
                    reuse = plan_recycled[0];
                    plan_recycled.delete(0);
                    plan_live[reuse] = 1'b1;
                end
                else if (plan_hw < CAPACITY)
                begin
                    plan_live[plan_hw] = 1'b1;
                    plan_hw++;
                end
            end
            REQ_FREE:
            begin
                if (index < plan_hw && plan_live[index])
                begin
                    plan_live[index] = 1'b0;
                    plan_recycled = {plan_recycled, index};
                end
            end
            REQ_CLEAR:
            begin
                plan_recycled.delete();
                plan_hw = 0;
                foreach (plan_live[i])
                    plan_live[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_live();
        int first;
        int slot;
        if (plan_hw == 0)
            return -1;
        first = $urandom_range(0, plan_hw - 1);
        for (int k = 0; k < plan_hw; k++)
        begin
            slot = (first + k) % plan_hw;
            if (plan_live[slot])
                return slot;
        end
        return -1;
    endfunction

    task automatic add_random_free();
        int slot;
        slot = pick_live();
        if (slot < 0)
            add_request(REQ_ALLOC, IDX_W'($urandom_range(0, 255)), 1'b0);
        else
            add_request(REQ_FREE, IDX_W'(slot), 1'b0);
    endtask

    // Driver: present the next request, holding it while busy.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= REQ_ALLOC;
            free_index <= '0;
            recycle_head = '0;
            recycle_tail = '0;
            recycle_count = '0;
            fresh_mark = '0;
            in_flight = 0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                resolve_request(req_type, free_index, predicted);
                expected_results = {expected_results, predicted};
                accepted_total++;
            end
            in_flight = in_flight + int'(took) - int'(done);
            if (!start || took)
            begin
                if (request_q.size() != 0 && !(request_q[0].drain && in_flight != 0)
                    && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    start <= 1'b1;
                    req_type <= request_q[0].kind;
                    free_index <= request_q[0].index;
                    request_q.delete(0);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: match each strobed result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: unit_index %0d status %0d", unit_index, status);
                error_count++;
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (unit_index !== want.unit_index)
                begin
                    $error("unit_index: expected %0d, actual %0d", want.unit_index, unit_index);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("** fifo_free_list_unit_allocator_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int len;
        int roll;
        int slot;

        // Directed: fresh allocs, free, double free, range, reuse order, clear.
        add_request(REQ_ALLOC, 8'hFF, 1'b0);
        add_request(REQ_ALLOC, 8'h00, 1'b0);
        add_request(REQ_ALLOC, 8'h55, 1'b0);
        add_request(REQ_FREE, 8'd1, 1'b0);
        add_request(REQ_FREE, 8'd1, 1'b0);
        add_request(REQ_FREE, 8'hFF, 1'b0);
        add_request(REQ_FREE, 8'd3, 1'b0);
        add_request(REQ_FREE, 8'd0, 1'b0);
        add_request(REQ_ALLOC, 8'h00, 1'b0);
        add_request(REQ_ALLOC, 8'h00, 1'b0);
        add_request(REQ_ALLOC, 8'hAA, 1'b0);
        add_request(REQ_UNKNOWN, 8'hAA, 1'b0);
        add_request(REQ_CLEAR, 8'h0F, 1'b1);
        // stale flag below the old mark must read as out of range
        add_request(REQ_FREE, 8'd0, 1'b0);
        add_request(REQ_ALLOC, 8'hF0, 1'b0);
        add_request(REQ_FREE, 8'd0, 1'b0);
        add_request(REQ_FREE, 8'd0, 1'b0);
        add_request(REQ_ALLOC, 8'h00, 1'b0);
        add_request(REQ_CLEAR, 8'hFF, 1'b0);

        // Fill every index, run into full, free random live indices and one of them twice, then reallocate.
        while (!(plan_hw == CAPACITY && plan_recycled.size() == 0))
            add_request(REQ_ALLOC, IDX_W'($urandom_range(0, 255)), 1'b0);
        add_request(REQ_ALLOC, IDX_W'($urandom_range(0, 255)), 1'b0);
        add_request(REQ_ALLOC, IDX_W'($urandom_range(0, 255)), 1'b0);
        repeat (12)
            add_random_free();
        add_request(REQ_FREE, plan_recycled[plan_recycled.size() - 1], 1'b0);
        repeat (6)
            add_request(REQ_ALLOC, IDX_W'($urandom_range(0, 255)), 1'b0);

        while (request_q.size() < ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                add_request(REQ_CLEAR, IDX_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            len = $urandom_range(15, 40);
            for (int n = 0; n < len; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    add_request(REQ_ALLOC, IDX_W'($urandom_range(0, 255)), n == 0);
                else if (roll < 88)
                    add_random_free();
                else if (roll < 93)
                    add_request(REQ_FREE, IDX_W'($urandom_range(0, 255)), 1'b0);
                else if (roll < 97)
                begin
                    // aim at an index already back in the free queue
                    if (plan_recycled.size() != 0)
                        slot = int'(plan_recycled[$urandom_range(0, plan_recycled.size() - 1)]);
                    else
                        slot = $urandom_range(0, 255);
                    add_request(REQ_FREE, IDX_W'(slot), 1'b0);
                end
                else
                    add_request(REQ_UNKNOWN, IDX_W'($urandom_range(0, 255)), 1'b0);
            end
        end

        @(posedge rst_n);
        do
            @(posedge clk);
        while (request_q.size() != 0 || in_flight != 0 || start);
        repeat (TAIL) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** fifo_free_list_unit_allocator_top: PASSED **");
        else
            $display("** fifo_free_list_unit_allocator_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ffla_pkg.sv
hw/rtl/ffla_ctrl.sv
hw/rtl/ffla_dp.sv
hw/rtl/fifo_free_list_unit_allocator_top.sv
bench/tb_fifo_free_list_unit_allocator_top.sv
